FILE: hw/rtl/iom_pkg.sv
// Types and constants shared by the interval ownership map and its checker.
// No dependencies.
`default_nettype none
package iom_pkg;

    // Boundary addresses are kept in 26-bit two's complement form. Inputs are
    // 24-bit unsigned, so the two sentinels only need to sit outside that range.
    localparam int ADDR_W = 26;
    localparam int OWN_W  = 9;

    localparam logic signed [ADDR_W-1:0] ADDR_MIN = {1'b1, {(ADDR_W-1){1'b0}}};
    localparam logic signed [ADDR_W-1:0] ADDR_MAX = {1'b0, {(ADDR_W-1){1'b1}}};

    localparam logic signed [OWN_W-1:0] OWN_END         = -9'sd4;
    localparam logic signed [OWN_W-1:0] OWN_NOT_IN_FILE = -9'sd3;
    localparam logic signed [OWN_W-1:0] OWN_FREE        = -9'sd1;

    localparam logic FUNC_CHANGE = 1'b0;
    localparam logic FUNC_CHECK  = 1'b1;

    typedef struct packed {
        logic signed [ADDR_W-1:0] addr;
        logic signed [OWN_W-1:0]  own;
    } t_entry;

    typedef enum logic [4:0] {
        ST_INIT0, ST_INIT1, ST_IDLE, ST_OUT,
        ST_C1_RD, ST_C1_EV, ST_C2_RD, ST_C2_EV,
        ST_F_RD, ST_F_EV, ST_S1_RD, ST_S1_A, ST_S1_B,
        ST_B_RD, ST_B_A, ST_B_N, ST_B_OWN, ST_B_P, ST_B_NX, ST_B_Q, ST_B_INC,
        ST_SP_START, ST_SP_RD, ST_SP_WR, ST_SP_INS,
        ST_RM_RD, ST_RM_WR
    } t_state;

endpackage
`default_nettype wire

FILE: hw/rtl/interval_owner_map_unit.sv
// Interval ownership map: sorted boundary table in a single-port-read RAM,
// walked by a sequencer. Depends on iom_pkg.
// A check walks the boundaries up to start and then the spans up to end; a
// change walks the boundaries up to start, then the spans in the range,
// and each split or merge moves the entries above it in the table.
// One item at a time: the input is not ready until the result is transferred.
// Reset: synchronous; the two sentinel entries are written in ST_INIT0 and
// ST_INIT1 after reset, during which no item is accepted.
`default_nettype none
module interval_owner_map_unit
    import iom_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_func,
    input  wire logic [23:0]              i_start_addr,
    input  wire logic [23:0]              i_end_addr,
    input  wire logic signed [OWN_W-1:0]  i_from_owner,
    input  wire logic signed [OWN_W-1:0]  i_to_owner,
    input  wire logic signed [OWN_W-1:0]  i_query_owner,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed [OWN_W-1:0]       o_found_owner,
    output logic                          o_overflow
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = CW + 1;
    localparam logic [EW-1:0] MAX_E = EW'(MAX_ENTRIES);

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rd;

    t_state r_state, n_state, r_ret, n_ret;
    logic [IW-1:0] r_i, n_i, r_k, n_k, r_sp_idx, n_sp_idx;
    logic [CW-1:0] r_cnt, n_cnt;
    logic signed [ADDR_W-1:0] r_start, n_start, r_end, n_end;
    logic signed [ADDR_W-1:0] r_sp_addr, n_sp_addr, r_cur_a, n_cur_a;
    logic signed [OWN_W-1:0] r_sp_own, n_sp_own, r_cur_o, n_cur_o;
    logic signed [OWN_W-1:0] r_from, n_from, r_to, n_to, r_query, n_query;
    logic signed [OWN_W-1:0] r_found, n_found;
    logic r_ovf, n_ovf;

    logic [IW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    t_entry        wr_data;
    logic [EW-1:0] ie, ke, ce;

    assign ie = EW'(r_i);
    assign ke = EW'(r_k);
    assign ce = EW'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT0;
            r_ret   <= ST_IDLE;
            r_cnt   <= CW'(2);
            r_i     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_k     <= n_k;
        end
        r_sp_idx  <= n_sp_idx;
        r_sp_addr <= n_sp_addr;
        r_sp_own  <= n_sp_own;
        r_cur_a   <= n_cur_a;
        r_cur_o   <= n_cur_o;
        r_start   <= n_start;
        r_end     <= n_end;
        r_from    <= n_from;
        r_to      <= n_to;
        r_query   <= n_query;
        r_found   <= n_found;
        r_ovf     <= n_ovf;
    end

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_cnt     = r_cnt;
        n_i       = r_i;
        n_k       = r_k;
        n_sp_idx  = r_sp_idx;
        n_sp_addr = r_sp_addr;
        n_sp_own  = r_sp_own;
        n_cur_a   = r_cur_a;
        n_cur_o   = r_cur_o;
        n_start   = r_start;
        n_end     = r_end;
        n_from    = r_from;
        n_to      = r_to;
        n_query   = r_query;
        n_found   = r_found;
        n_ovf     = r_ovf;
        rd_addr   = r_i;
        wr_en     = 1'b0;
        wr_addr   = r_i;
        wr_data   = r_rd;

        case (r_state)
            ST_INIT0: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = '{addr: ADDR_MIN, own: OWN_NOT_IN_FILE};
                n_state = ST_INIT1;
            end
            ST_INIT1: begin
                wr_en   = 1'b1;
                wr_addr = IW'(1);
                wr_data = '{addr: ADDR_MAX, own: OWN_END};
                n_cnt   = CW'(2);
                n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_start = $signed({2'b00, i_start_addr});
                    n_end   = $signed({2'b00, i_end_addr});
                    n_from  = i_from_owner;
                    n_to    = i_to_owner;
                    n_query = i_query_owner;
                    n_found = '0;
                    n_ovf   = 1'b0;
                    n_i     = '0;
                    n_state = (i_func == FUNC_CHECK) ? ST_C1_RD : ST_F_RD;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            // Check: find the span holding start, then walk to end.
            ST_C1_RD: begin
                if (ie + EW'(2) < ce) begin
                    rd_addr = IW'(ie + EW'(1));
                    n_state = ST_C1_EV;
                end else begin
                    n_state = ST_C2_RD;
                end
            end
            ST_C1_EV: begin
                if (r_rd.addr <= r_start) begin
                    n_i     = r_i + IW'(1);
                    n_state = ST_C1_RD;
                end else begin
                    n_state = ST_C2_RD;
                end
            end
            ST_C2_RD: begin
                if (ie + EW'(1) < ce) begin
                    n_state = ST_C2_EV;
                end else begin
                    n_found = OWN_FREE;
                    n_state = ST_OUT;
                end
            end
            ST_C2_EV: begin
                if (r_rd.addr >= r_end) begin
                    n_found = OWN_FREE;
                    n_state = ST_OUT;
                end else if (r_rd.own != OWN_FREE && r_rd.own != r_query) begin
                    n_found = r_rd.own;
                    n_state = ST_OUT;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = ST_C2_RD;
                end
            end
            // Change: locate the first boundary at or above start.
            ST_F_RD: begin
                n_state = (ie + EW'(1) < ce) ? ST_F_EV : ST_S1_RD;
            end
            ST_F_EV: begin
                if (r_rd.addr < r_start) begin
                    n_i     = r_i + IW'(1);
                    n_state = ST_F_RD;
                end else begin
                    n_state = ST_S1_RD;
                end
            end
            ST_S1_RD: begin
                n_state = ST_S1_A;
            end
            ST_S1_A: begin
                n_cur_a = r_rd.addr;
                if (r_i == '0) begin
                    n_state = ST_B_RD;
                end else begin
                    rd_addr = r_i - IW'(1);
                    n_state = ST_S1_B;
                end
            end
            ST_S1_B: begin
                if (r_cur_a != r_start && r_rd.own == r_from) begin
                    n_sp_idx  = r_i;
                    n_sp_addr = r_start;
                    n_sp_own  = r_rd.own;
                    n_ret     = ST_B_RD;
                    n_state   = ST_SP_START;
                end else begin
                    n_state = ST_B_RD;
                end
            end
            // Main walk over the spans inside the range.
            ST_B_RD: begin
                n_state = (ie + EW'(1) < ce) ? ST_B_A : ST_OUT;
            end
            ST_B_A: begin
                n_cur_a = r_rd.addr;
                n_cur_o = r_rd.own;
                if (r_rd.addr >= r_end) begin
                    n_state = ST_OUT;
                end else begin
                    rd_addr = r_i + IW'(1);
                    n_state = ST_B_N;
                end
            end
            ST_B_N: begin
                if (r_rd.addr > r_end) begin
                    n_sp_idx  = r_i + IW'(1);
                    n_sp_addr = r_end;
                    n_sp_own  = r_cur_o;
                    n_ret     = ST_B_OWN;
                    n_state   = ST_SP_START;
                end else begin
                    n_state = ST_B_OWN;
                end
            end
            ST_B_OWN: begin
                if (r_cur_o == r_from) begin
                    wr_en   = 1'b1;
                    wr_addr = r_i;
                    wr_data = '{addr: r_cur_a, own: r_to};
                    if (r_i != '0) begin
                        rd_addr = r_i - IW'(1);
                        n_state = ST_B_P;
                    end else begin
                        n_state = ST_B_NX;
                    end
                end else begin
                    n_state = ST_B_INC;
                end
            end
            ST_B_P: begin
                // Same owner as the span below: this boundary is redundant.
                if (r_rd.own == r_to) begin
                    n_k     = r_i;
                    n_i     = r_i - IW'(1);
                    n_ret   = ST_B_NX;
                    n_state = ST_RM_RD;
                end else begin
                    n_state = ST_B_NX;
                end
            end
            ST_B_NX: begin
                if (ie + EW'(2) < ce) begin
                    rd_addr = r_i + IW'(1);
                    n_state = ST_B_Q;
                end else begin
                    n_state = ST_B_INC;
                end
            end
            ST_B_Q: begin
                if (r_rd.own == r_to) begin
                    n_k     = r_i + IW'(1);
                    n_ret   = ST_B_INC;
                    n_state = ST_RM_RD;
                end else begin
                    n_state = ST_B_INC;
                end
            end
            ST_B_INC: begin
                n_i     = r_i + IW'(1);
                n_state = ST_B_RD;
            end
            // Split: move entries up from the top, then insert.
            ST_SP_START: begin
                if (ce >= MAX_E) begin
                    n_ovf   = 1'b1;
                    n_state = ST_OUT;
                end else if (EW'(r_sp_idx) == ce) begin
                    n_state = ST_SP_INS;
                end else begin
                    n_k     = IW'(ce - EW'(1));
                    n_state = ST_SP_RD;
                end
            end
            ST_SP_RD: begin
                rd_addr = r_k;
                n_state = ST_SP_WR;
            end
            ST_SP_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_k + IW'(1);
                wr_data = r_rd;
                if (r_k == r_sp_idx) begin
                    n_state = ST_SP_INS;
                end else begin
                    n_k     = r_k - IW'(1);
                    n_state = ST_SP_RD;
                end
            end
            ST_SP_INS: begin
                wr_en   = 1'b1;
                wr_addr = r_sp_idx;
                wr_data = '{addr: r_sp_addr, own: r_sp_own};
                n_cnt   = r_cnt + CW'(1);
                n_state = r_ret;
            end
            // Remove: move entries down from the removed slot.
            ST_RM_RD: begin
                if (ke + EW'(1) < ce) begin
                    rd_addr = r_k + IW'(1);
                    n_state = ST_RM_WR;
                end else begin
                    n_cnt   = r_cnt - CW'(1);
                    n_state = r_ret;
                end
            end
            ST_RM_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_k;
                wr_data = r_rd;
                n_k     = r_k + IW'(1);
                n_state = ST_RM_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = (r_state == ST_OUT);
    assign o_found_owner = r_found;
    assign o_overflow    = r_ovf;

endmodule
`default_nettype wire

FILE: hw/rtl/iom_checker.sv
// Port-level checker for the interval ownership map, bound to the top level.
// Depends on iom_pkg.
`default_nettype none
module iom_checker
    import iom_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    o_in_ready,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_ready,
    input wire logic signed [OWN_W-1:0] o_found_owner,
    input wire logic                    o_overflow
);

    // A result held back by the sink must not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_found_owner)
            && $stable(o_overflow))
        else $error("result changed while stalled");

    // Only one item is in flight at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("accepted a second item while busy");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("ready while a result is pending");

    // An overflow only comes from a change, whose owner field reads zero.
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_found_owner == '0)
        else $error("overflow with a non-zero owner");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("handshake active straight after reset");

endmodule

bind interval_owner_map_unit iom_checker u_iom_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_found_owner (o_found_owner),
    .o_overflow    (o_overflow)
);
`default_nettype wire
